FILE: hw/rtl/onewire_bus_master_unit_macros.svh
// Assertion macros for the 1-Wire bus master unit.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef ONEWIRE_BUS_MASTER_UNIT_MACROS_SVH
`define ONEWIRE_BUS_MASTER_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define OWM_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle outside reset.
`define OWM_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

FILE: hw/rtl/owm_pkg.sv
// Shared types and constants for the 1-Wire bus master unit.
// No dependencies; imported by every module of the block.
package owm_pkg;

  // Width of the phase timer in bits.
  localparam int TIMER_BITS = 10;
  // Width of every timing register.
  localparam int CFG_W = 10;
  // Width used when a timer value is compared with a register value.
  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // Reset values of the timing registers, in microseconds.
  localparam logic [CFG_W-1:0] RESET_LOW_DEF      = CFG_W'(480);
  localparam logic [CFG_W-1:0] PRESENCE_WAIT_DEF  = CFG_W'(70);
  localparam logic [CFG_W-1:0] RESET_RECOVERY_DEF = CFG_W'(410);
  localparam logic [CFG_W-1:0] SHORT_LOW_DEF      = CFG_W'(6);
  localparam logic [CFG_W-1:0] LONG_LOW_DEF       = CFG_W'(60);
  localparam logic [CFG_W-1:0] SAMPLE_DELAY_DEF   = CFG_W'(9);
  localparam logic [CFG_W-1:0] SLOT_LEN_DEF       = CFG_W'(70);

  // Request codes of an input word; also the kind of operation in progress.
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // Operation phases.
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RST_LOW   = 3'd1,
    PH_RST_WAIT  = 3'd2,
    PH_RST_REC   = 3'd3,
    PH_SLOT_LOW  = 3'd4,
    PH_SLOT_WAIT = 3'd5,
    PH_SLOT_REST = 3'd6
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_RESET_LOW      = 3'd0,
    CFG_PRESENCE_WAIT  = 3'd1,
    CFG_RESET_RECOVERY = 3'd2,
    CFG_SHORT_LOW      = 3'd3,
    CFG_LONG_LOW       = 3'd4,
    CFG_SAMPLE_DELAY   = 3'd5,
    CFG_SLOT_LEN       = 3'd6
  } cfg_idx_t;

  // The full set of timing registers as seen by the engine.
  typedef struct packed {
    logic [CFG_W-1:0] reset_low_us;
    logic [CFG_W-1:0] presence_wait_us;
    logic [CFG_W-1:0] reset_recovery_us;
    logic [CFG_W-1:0] short_low_us;
    logic [CFG_W-1:0] long_low_us;
    logic [CFG_W-1:0] sample_delay_us;
    logic [CFG_W-1:0] slot_len_us;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       presence;
  } res_t;

endpackage

FILE: hw/rtl/owm_cfg.sv
// Timing register file of the 1-Wire bus master unit.
// Depends on owm_pkg for the register indexes and reset values.
module owm_cfg
  import owm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t regs;

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.reset_low_us      <= RESET_LOW_DEF;
      regs.presence_wait_us  <= PRESENCE_WAIT_DEF;
      regs.reset_recovery_us <= RESET_RECOVERY_DEF;
      regs.short_low_us      <= SHORT_LOW_DEF;
      regs.long_low_us       <= LONG_LOW_DEF;
      regs.sample_delay_us   <= SAMPLE_DELAY_DEF;
      regs.slot_len_us       <= SLOT_LEN_DEF;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RESET_LOW:      regs.reset_low_us      <= cfg_data;
        CFG_PRESENCE_WAIT:  regs.presence_wait_us  <= cfg_data;
        CFG_RESET_RECOVERY: regs.reset_recovery_us <= cfg_data;
        CFG_SHORT_LOW:      regs.short_low_us      <= cfg_data;
        CFG_LONG_LOW:       regs.long_low_us       <= cfg_data;
        CFG_SAMPLE_DELAY:   regs.sample_delay_us   <= cfg_data;
        CFG_SLOT_LEN:       regs.slot_len_us       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: hw/rtl/owm_core.sv
// Bus timing engine of the 1-Wire bus master unit: operation state and
// the single-pass update for one word. Depends on owm_pkg.
module owm_core
  import owm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [1:0] req_type,
  input  logic [7:0] tx_byte,
  input  logic       bus_level,
  input  cfg_t       cfg,
  output res_t       res
);

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] timer, timer_next, timer_inc;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic                  presence_seen, presence_seen_next;
  req_t                  op_kind, op_kind_next;

  logic [CFG_W-1:0] wr_low;
  logic [CFG_W:0]   used;
  logic [CFG_W-1:0] rest;
  logic             rest_nz;
  logic             fin, after_sample, end_slot;
  req_t             req;

  // True when the advanced timer has reached a phase length or has saturated.
  function automatic logic timer_hit(input logic [TIMER_BITS-1:0] t,
                                     input logic [CFG_W-1:0] len);
    timer_hit = (CMP_W'(t) >= CMP_W'(len)) || (t == TIMER_MAX);
  endfunction

  assign req       = req_t'(req_type);
  assign timer_inc = (timer == TIMER_MAX) ? timer : timer + 1'b1;

  // Slot lengths: low time for the current write bit and the released rest.
  assign wr_low  = shift_byte[0] ? cfg.short_low_us : cfg.long_low_us;
  assign used    = (op_kind == REQ_READ) ?
                   ({1'b0, cfg.short_low_us} + {1'b0, cfg.sample_delay_us}) :
                   {1'b0, wr_low};
  assign rest_nz = {1'b0, cfg.slot_len_us} > used;
  assign rest    = rest_nz ? CFG_W'({1'b0, cfg.slot_len_us} - used) : '0;

  // Next state and result for the word at hand.
  always_comb begin
    phase_next         = phase;
    timer_next         = timer;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_seen_next = presence_seen;
    op_kind_next       = op_kind;
    fin                = 1'b0;
    after_sample       = 1'b0;
    end_slot           = 1'b0;
    res.drive_low      = (phase == PH_RST_LOW) || (phase == PH_SLOT_LOW);
    res.busy_res       = 1'b1;

    if (req != REQ_TICK) begin
      // A command starts an operation only from idle.
      if (phase == PH_IDLE) begin
        op_kind_next   = req;
        timer_next     = '0;
        bit_index_next = '0;
        if (req == REQ_RESET) begin
          presence_seen_next = 1'b0;
          phase_next         = PH_RST_LOW;
        end else begin
          shift_byte_next = (req == REQ_WRITE) ? tx_byte : 8'h00;
          phase_next      = PH_SLOT_LOW;
        end
        res.drive_low = 1'b1;
      end
    end else begin
      timer_next = timer_inc;
      unique case (phase)
        PH_RST_LOW: begin
          if (timer_hit(timer_inc, cfg.reset_low_us)) begin
            phase_next = PH_RST_WAIT;
            timer_next = '0;
          end
        end
        PH_RST_WAIT: begin
          if (timer_hit(timer_inc, cfg.presence_wait_us)) begin
            presence_seen_next = ~bus_level;
            phase_next         = PH_RST_REC;
            timer_next         = '0;
          end
        end
        PH_RST_REC: begin
          if (timer_hit(timer_inc, cfg.reset_recovery_us)) begin
            phase_next = PH_IDLE;
            timer_next = '0;
            fin        = 1'b1;
          end
        end
        PH_SLOT_LOW: begin
          if (op_kind == REQ_READ) begin
            if (timer_hit(timer_inc, cfg.short_low_us)) begin
              phase_next = PH_SLOT_WAIT;
              timer_next = '0;
            end
          end else if (timer_hit(timer_inc, wr_low)) begin
            after_sample = 1'b1;
          end
        end
        PH_SLOT_WAIT: begin
          if (timer_hit(timer_inc, cfg.sample_delay_us)) begin
            shift_byte_next = {bus_level, shift_byte[7:1]};
            after_sample    = 1'b1;
          end
        end
        PH_SLOT_REST: begin
          if (timer_hit(timer_inc, rest)) begin
            end_slot = 1'b1;
          end
        end
        default: begin
          // Idle, and any code that names no phase, counts as idle.
          phase_next   = PH_IDLE;
          timer_next   = timer;
          res.busy_res = 1'b0;
        end
      endcase

      // After the low part or the sample: rest of the slot, or slot end.
      if (after_sample) begin
        if (rest_nz) begin
          phase_next = PH_SLOT_REST;
          timer_next = '0;
        end else begin
          end_slot = 1'b1;
        end
      end

      // Slot end: finish the byte or move to the next bit.
      if (end_slot) begin
        timer_next = '0;
        if (bit_index == 3'd7) begin
          phase_next = PH_IDLE;
          fin        = 1'b1;
        end else begin
          bit_index_next = bit_index + 3'd1;
          if (op_kind == REQ_WRITE) begin
            shift_byte_next = {1'b0, shift_byte[7:1]};
          end
          phase_next = PH_SLOT_LOW;
        end
      end
    end

    if (fin) begin
      res.busy_res = 1'b0;
    end
    res.done_res = fin;
    res.rx_byte  = (fin && (op_kind == REQ_READ)) ? shift_byte_next : 8'h00;
    res.presence = fin && (op_kind == REQ_RESET) && presence_seen;
  end

  // State registers advance once per word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      timer         <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_seen <= 1'b0;
      op_kind       <= REQ_TICK;
    end else if (go) begin
      phase         <= phase_next;
      timer         <= timer_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_seen <= presence_seen_next;
      op_kind       <= op_kind_next;
    end
  end

endmodule

FILE: hw/rtl/onewire_bus_master_unit.sv
// Standard-speed 1-Wire bus master.
//
// Input channel (in_valid / in_stall): one word per microsecond tick or
// command; req_type selects tick, reset, write byte or read byte, tx_byte
// carries the write data and bus_level the sampled line.
// Output channel (out_valid / out_stall): exactly one result word for every
// input word: drive level, busy, done, and rx_byte or presence with done.
// Timing registers are written through cfg_we / cfg_index / cfg_data; the
// user must write them only while no operation is running, which the block
// does not enforce; there is no read-back.
// A word passes two registers: the input register, then the result register.
// Throughput: one word per cycle when not stalled, by the single-pass update.
// When the receiver stalls, the result word holds and the input register
// keeps one more word; in_stall rises only when both are full.
// Reset (rst, synchronous) clears both channels, returns the engine to idle
// and loads the standard-speed timing defaults.
// Depends on owm_pkg, owm_cfg, owm_core and the assertion macro header.
`include "onewire_bus_master_unit_macros.svh"

module onewire_bus_master_unit
  import owm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       req_type,
  input  logic [7:0]       tx_byte,
  input  logic             bus_level,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             drive_low,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       rx_byte,
  output logic             presence
);

  cfg_t       cfg;
  res_t       res;
  logic       in_q_valid;
  logic [1:0] req_q;
  logic [7:0] tx_q;
  logic       lvl_q;
  logic       advance;
  logic       go;

  // The pipeline moves whenever the result register is free or being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;
  assign go       = in_q_valid && advance;

  owm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_q <= req_type;
      tx_q  <= tx_byte;
      lvl_q <= bus_level;
    end
  end

  owm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .req_type  (req_q),
    .tx_byte   (tx_q),
    .bus_level (lvl_q),
    .cfg       (cfg),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      drive_low <= res.drive_low;
      busy_res  <= res.busy_res;
      done_res  <= res.done_res;
      rx_byte   <= res.rx_byte;
      presence  <= res.presence;
    end
  end

  // A completed operation is no longer busy.
  `OWM_IMPLIES(a_done_idle, out_valid && done_res, !busy_res, "done word is still busy")
  // Read data and presence are zero outside a done word.
  `OWM_IMPLIES(a_data_quiet, out_valid && !done_res, (rx_byte == 8'h00) && !presence, "data outside done word")
  // The input side stalls only while a word waits in the input register.
  `OWM_IMPLIES(a_stall_has_word, in_stall, in_q_valid && out_valid && out_stall, "stall without a held word")

endmodule
